### rtl/whcp_pkg.sv
// Types, codes and constants shared by the WAVE header parser modules.
// No dependencies.
`default_nettype none

package whcp_pkg;

  localparam int FILE_HDR_LEN = 12;
  localparam int FMT_MIN_LEN  = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int DIV_STEPS    = 32;

  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;  // "fmt "
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;  // "data"

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  typedef enum logic [1:0] {
    PH_FILE,
    PH_CHDR,
    PH_BODY,
    PH_PAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_FMT,
    KIND_DATA
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIVIDE,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        wave_ok;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] bytes_per_second;
    logic [15:0] block_alignment;
    logic [15:0] sample_bits;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
  } out_item_t;

  // Verdict request from the parser: raw fields plus the structural checks.
  typedef struct packed {
    logic      pre_ok;
    out_item_t fields;
  } verdict_req_t;

  // "RIFF" at bytes 0..3 and "WAVE" at bytes 8..11; bytes 4..7 are not checked.
  function automatic logic tag_used(input logic [3:0] idx);
    logic r;
    case (idx)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd10, 4'd11: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tag_byte(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:  r = 8'h52;  // R
      4'd1:  r = 8'h49;  // I
      4'd2:  r = 8'h46;  // F
      4'd3:  r = 8'h46;  // F
      4'd8:  r = 8'h57;  // W
      4'd9:  r = 8'h41;  // A
      4'd10: r = 8'h56;  // V
      4'd11: r = 8'h45;  // E
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/whcp_front.sv
// Byte-level parser: tag checks, chunk walk, fmt/data capture.
// Issues one verdict request per file on the final byte. Uses whcp_pkg.
`default_nettype none

module whcp_front #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire whcp_pkg::in_item_t      in_data_i,
  output logic                         push_o,
  output whcp_pkg::verdict_req_t       req_o
);
  import whcp_pkg::*;

  localparam int PW = POSITION_WIDTH;

  logic                accept;
  logic [7:0]          b;

  // control state
  logic [PW:0]         pos_q, pos_d;
  phase_e              phase_q, phase_d;
  logic [2:0]          hdr_cnt_q, hdr_cnt_d;
  logic [31:0]         remain_q, remain_d;
  kind_e               kind_q, kind_d;
  logic                pad_q, pad_d;
  logic [4:0]          fmt_idx_q, fmt_idx_d;
  logic                fmt_seen_q, fmt_seen_d;
  logic                data_seen_q, data_seen_d;
  logic                err_q, err_d;

  // captured payload
  logic [63:0]         shift_q, shift_d;
  logic [127:0]        fmt_q, fmt_d;
  logic [PW-1:0]       offset_q, offset_d;
  logic [31:0]         dsize_q, dsize_d;

  logic [63:0]         shift_new;
  logic [31:0]         chunk_id;
  logic [31:0]         hdr_size;

  assign accept    = in_valid_i && !in_stall_i;
  assign b         = in_data_i.data_byte;
  assign shift_new = {shift_q[55:0], b};
  assign chunk_id  = shift_new[63:32];
  assign hdr_size  = {shift_new[7:0], shift_new[15:8], shift_new[23:16], shift_new[31:24]};

  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    remain_d    = remain_q;
    kind_d      = kind_q;
    pad_d       = pad_q;
    fmt_idx_d   = fmt_idx_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    err_d       = err_q;
    shift_d     = shift_q;
    fmt_d       = fmt_q;
    offset_d    = offset_q;
    dsize_d     = dsize_q;

    if (accept) begin
      // byte count saturates at 2^PW
      if (!pos_q[PW]) begin
        pos_d = pos_q + (PW+1)'(1);
      end

      case (phase_q)
        PH_FILE: begin
          if (pos_q < (PW+1)'(FILE_HDR_LEN) && tag_used(pos_q[3:0]) &&
              tag_byte(pos_q[3:0]) != b) begin
            err_d = 1'b1;
          end
          if (pos_d >= (PW+1)'(FILE_HDR_LEN)) begin
            phase_d   = PH_CHDR;
            hdr_cnt_d = 3'd0;
          end
        end
        PH_CHDR: begin
          shift_d   = shift_new;
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_cnt_q == 3'd7) begin
            hdr_cnt_d = 3'd0;
            kind_d    = KIND_OTHER;
            if (chunk_id == TAG_FMT) begin
              if (hdr_size < 32'(FMT_MIN_LEN)) begin
                err_d = 1'b1;
              end
              kind_d     = KIND_FMT;
              fmt_d      = '0;
              fmt_seen_d = 1'b1;
            end else if (chunk_id == TAG_DATA) begin
              if (hdr_size == 32'd0 || pos_d[PW]) begin
                err_d = 1'b1;
              end
              kind_d      = KIND_DATA;
              offset_d    = pos_d[PW-1:0];
              dsize_d     = hdr_size;
              data_seen_d = 1'b1;
            end
            fmt_idx_d = 5'd0;
            remain_d  = hdr_size;
            pad_d     = hdr_size[0];
            phase_d   = (hdr_size == 32'd0) ? PH_CHDR : PH_BODY;
          end
        end
        PH_BODY: begin
          if (kind_q == KIND_FMT && fmt_idx_q < 5'd16) begin
            fmt_d[{fmt_idx_q[3:0], 3'b000} +: 8] = b;
            fmt_idx_d = fmt_idx_q + 5'd1;
          end
          remain_d = remain_q - 32'd1;
          if (remain_q == 32'd1) begin
            phase_d = pad_q ? PH_PAD : PH_CHDR;
            pad_d   = 1'b0;
          end
        end
        PH_PAD: begin
          phase_d = PH_CHDR;
        end
        default: begin
          phase_d = PH_CHDR;
        end
      endcase
    end

    // verdict request is built from the state after this byte
    req_o.pre_ok = !err_d && phase_d != PH_FILE && phase_d != PH_BODY &&
                   fmt_seen_d && data_seen_d;
    req_o.fields.wave_ok          = 1'b0;
    req_o.fields.format_tag       = fmt_d[15:0];
    req_o.fields.channel_count    = fmt_d[31:16];
    req_o.fields.sample_rate      = fmt_d[63:32];
    req_o.fields.bytes_per_second = fmt_d[95:64];
    req_o.fields.block_alignment  = fmt_d[111:96];
    req_o.fields.sample_bits      = fmt_d[127:112];
    req_o.fields.payload_offset   = 32'(offset_d);
    req_o.fields.payload_size     = dsize_d;
    push_o = accept && in_data_i.last_byte;

    // the final byte returns the parser to its reset state
    if (push_o) begin
      pos_d       = '0;
      phase_d     = PH_FILE;
      hdr_cnt_d   = 3'd0;
      remain_d    = 32'd0;
      kind_d      = KIND_OTHER;
      pad_d       = 1'b0;
      fmt_idx_d   = 5'd0;
      fmt_seen_d  = 1'b0;
      data_seen_d = 1'b0;
      err_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_FILE;
      hdr_cnt_q   <= 3'd0;
      remain_q    <= 32'd0;
      kind_q      <= KIND_OTHER;
      pad_q       <= 1'b0;
      fmt_idx_q   <= 5'd0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      remain_q    <= remain_d;
      kind_q      <= kind_d;
      pad_q       <= pad_d;
      fmt_idx_q   <= fmt_idx_d;
      fmt_seen_q  <= fmt_seen_d;
      data_seen_q <= data_seen_d;
      err_q       <= err_d;
    end
  end

  // fields are only read once the matching seen flag is set
  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    fmt_q    <= fmt_d;
    offset_q <= offset_d;
    dsize_q  <= dsize_d;
  end

endmodule

`default_nettype wire

### rtl/whcp_queue.sv
// Short FIFO of verdict requests between the parser and the checker.
// Uses whcp_pkg.
`default_nettype none

module whcp_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire whcp_pkg::verdict_req_t  push_data_i,
  input  wire logic                    pop_i,
  output whcp_pkg::verdict_req_t       pop_data_o,
  output logic                         full_o,
  output logic                         empty_o
);
  import whcp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  verdict_req_t       slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o     = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/whcp_back.sv
// Verdict stage: field checks, bit-serial remainder of data size by block
// alignment, and the result register. Uses whcp_pkg.
`default_nettype none

module whcp_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire whcp_pkg::verdict_req_t  q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output whcp_pkg::out_item_t          out_data_o
);
  import whcp_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  back_state_e     state_q, state_d;
  verdict_req_t    req_q;
  out_item_t       result_q;
  logic [15:0]     rem_q;
  logic [31:0]     dvd_q;
  logic [CNT_W-1:0] cnt_q;

  logic            fields_ok;
  logic            last_step;
  logic [16:0]     rem_shift;
  logic [16:0]     rem_sub;
  logic [15:0]     rem_new;
  out_item_t       pass_result;

  assign fields_ok = req_q.pre_ok &&
    (req_q.fields.format_tag == FMT_PCM || req_q.fields.format_tag == FMT_FLOAT) &&
    (req_q.fields.channel_count == 16'd1 || req_q.fields.channel_count == 16'd2) &&
    req_q.fields.sample_rate != 32'd0 && req_q.fields.bytes_per_second != 32'd0 &&
    req_q.fields.block_alignment != 16'd0 && req_q.fields.sample_bits != 16'd0;

  // one restoring-division step per cycle, remainder only
  assign rem_shift = {rem_q, dvd_q[31]};
  assign rem_sub   = rem_shift - {1'b0, req_q.fields.block_alignment};
  assign rem_new   = rem_sub[16] ? rem_shift[15:0] : rem_sub[15:0];
  assign last_step = cnt_q == CNT_W'(DIV_STEPS - 1);

  always_comb begin
    pass_result         = req_q.fields;
    pass_result.wave_ok = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = BK_CHECK;
        end
      end
      BK_CHECK: begin
        state_d = fields_ok ? BK_DIVIDE : BK_DONE;
      end
      BK_DIVIDE: begin
        if (last_step) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_stall_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o     = !q_empty_i;
      BK_DONE: out_valid_o = 1'b1;
      default: begin
        q_pop_o     = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign out_data_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      req_q <= q_data_i;
    end
    if (state_q == BK_CHECK) begin
      rem_q    <= 16'd0;
      dvd_q    <= req_q.fields.payload_size;
      cnt_q    <= '0;
      result_q <= '0;
    end
    if (state_q == BK_DIVIDE) begin
      rem_q <= rem_new;
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q + CNT_W'(1);
      if (last_step && rem_new == 16'd0) begin
        result_q <= pass_result;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/wave_header_chunk_parser.sv
// RIFF WAVE header parser top level: parser front end, request queue, verdict stage.
// Uses whcp_pkg, whcp_front, whcp_queue, whcp_back.
`default_nettype none

// Takes one file byte per cycle, last_byte marking the end of a file, and
// returns one verdict per file. Bytes flow at one per cycle without pause;
// the input stalls only while two verdict requests are already queued. A
// verdict goes out from the check state when a field check fails, and
// only after the data size has been tested against the block alignment
// otherwise: that test is a bit-serial remainder unit, one bit of the
// 32-bit data size per cycle. The verdict waits in an output register while
// the parser keeps taking bytes of the next file. POSITION_WIDTH sets the
// byte counter: a data chunk that starts at or beyond 2^POSITION_WIDTH fails.
module wave_header_chunk_parser #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire whcp_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output whcp_pkg::out_item_t       out_data_o
);
  import whcp_pkg::*;

  logic          push;
  verdict_req_t  push_req;
  logic          pop;
  verdict_req_t  pop_req;
  logic          q_full;
  logic          q_empty;

  assign in_stall_o = q_full;

  whcp_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .req_o      (push_req)
  );

  whcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_req),
    .pop_i       (pop),
    .pop_data_o  (pop_req),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  whcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_req),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### test/wave_header_chunk_parser_checker.sv
`timescale 1ns / 1ps
// Checker for wave_header_chunk_parser: follows the byte stream, keeps its own
// copy of the chunk walk, queues expected verdicts and compares each result.
// Depends on whcp_pkg.
module wave_header_chunk_parser_checker #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire whcp_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire whcp_pkg::out_item_t out_data_i,
  output int                       mismatch_count_o,
  output int                       verdicts_pending_o
);
  import whcp_pkg::*;

  localparam int          MAX_REPORTS = 10;
  localparam int          NUM_FIELDS  = 9;
  localparam logic [32:0] POS_LIMIT   = 33'd1 << POSITION_WIDTH;
  localparam logic [15:0] MONO        = 16'd1;
  localparam logic [15:0] STEREO      = 16'd2;
  // "RIFF", size (unchecked), "WAVE"
  localparam logic [95:0] FILE_TAG    = {32'h5249_4646, 32'h0, 32'h5741_5645};

  logic [32:0] byte_count;
  phase_e      phase;
  logic [63:0] hdr_shift;
  int unsigned hdr_bytes;
  logic [31:0] body_left;
  kind_e       kind;
  logic        pad_due;
  int unsigned fmt_bytes;
  logic [63:0] fmt_lo;
  logic [63:0] fmt_hi;
  logic [31:0] body_offset;
  logic [31:0] data_size;
  logic        seen_fmt;
  logic        seen_data;
  logic        hdr_error;
  out_item_t   verdict_q[$];
  int          verdicts_seen;

  task automatic clear_parser();
    byte_count  = '0;
    phase       = PH_FILE;
    hdr_shift   = '0;
    hdr_bytes   = 0;
    body_left   = '0;
    kind        = KIND_OTHER;
    pad_due     = 1'b0;
    fmt_bytes   = 0;
    fmt_lo      = '0;
    fmt_hi      = '0;
    body_offset = '0;
    data_size   = '0;
    seen_fmt    = 1'b0;
    seen_data   = 1'b0;
    hdr_error   = 1'b0;
  endtask

  function automatic logic [31:0] field_val(input out_item_t v, input int k);
    case (k)
      0:       return {31'd0, v.wave_ok};
      1:       return {16'd0, v.format_tag};
      2:       return {16'd0, v.channel_count};
      3:       return v.sample_rate;
      4:       return v.bytes_per_second;
      5:       return {16'd0, v.block_alignment};
      6:       return {16'd0, v.sample_bits};
      7:       return v.payload_offset;
      default: return v.payload_size;
    endcase
  endfunction

  function automatic string field_name(input int k);
    case (k)
      0:       return "wave_ok";
      1:       return "format_tag";
      2:       return "channel_count";
      3:       return "sample_rate";
      4:       return "bytes_per_second";
      5:       return "block_alignment";
      6:       return "sample_bits";
      7:       return "payload_offset";
      default: return "payload_size";
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [32:0] prev;
    int          idx;
    logic [31:0] csize;
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] depth;
    logic [31:0] rate;
    logic [31:0] bps;
    logic        ok;
    out_item_t   want;
    if (!rst_ni) begin
      clear_parser();
      verdict_q.delete();
      mismatch_count_o = 0;
      verdicts_seen = 0;
      verdicts_pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        prev = byte_count;
        if (byte_count < POS_LIMIT) byte_count++;
        case (phase)
          PH_FILE: begin
            idx = int'(prev);
            if (idx < FILE_HDR_LEN && (idx < 4 || idx >= 8)) begin
              if (FILE_TAG[95 - 8 * idx -: 8] != in_data_i.data_byte) hdr_error = 1'b1;
            end
            if (byte_count >= FILE_HDR_LEN) begin
              phase = PH_CHDR;
              hdr_bytes = 0;
            end
          end
          PH_CHDR: begin
            hdr_shift = {hdr_shift[55:0], in_data_i.data_byte};
            hdr_bytes++;
            if (hdr_bytes >= 8) begin
              hdr_bytes = 0;
              // size field is little endian in the low four header bytes
              csize = {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16], hdr_shift[31:24]};
              kind = KIND_OTHER;
              if (hdr_shift[63:32] == TAG_FMT) begin
                if (csize < FMT_MIN_LEN) hdr_error = 1'b1;
                kind = KIND_FMT;
                fmt_lo = '0;
                fmt_hi = '0;
                seen_fmt = 1'b1;
              end else if (hdr_shift[63:32] == TAG_DATA) begin
                if (csize == 0 || byte_count >= POS_LIMIT) hdr_error = 1'b1;
                kind = KIND_DATA;
                body_offset = byte_count[31:0];
                data_size = csize;
                seen_data = 1'b1;
              end
              fmt_bytes = 0;
              body_left = csize;
              pad_due = csize[0];
              phase = (csize == 0) ? PH_CHDR : PH_BODY;
            end
          end
          PH_BODY: begin
            if (kind == KIND_FMT && fmt_bytes < FMT_MIN_LEN) begin
              if (fmt_bytes < 8) fmt_lo[8 * fmt_bytes +: 8] = in_data_i.data_byte;
              else fmt_hi[8 * (fmt_bytes - 8) +: 8] = in_data_i.data_byte;
              fmt_bytes++;
            end
            body_left--;
            if (body_left == 0) begin
              phase = pad_due ? PH_PAD : PH_CHDR;
              pad_due = 1'b0;
            end
          end
          default: phase = PH_CHDR;
        endcase

        if (in_data_i.last_byte) begin
          code  = fmt_lo[15:0];
          chans = fmt_lo[31:16];
          rate  = fmt_lo[63:32];
          bps   = fmt_hi[31:0];
          align = fmt_hi[47:32];
          depth = fmt_hi[63:48];
          // a header fragment or a missing pad at the end is fine
          ok = !hdr_error && phase != PH_FILE && phase != PH_BODY && seen_fmt && seen_data
               && (code == FMT_PCM || code == FMT_FLOAT) && (chans == MONO || chans == STEREO)
               && rate != 0 && bps != 0 && align != 0 && depth != 0;
          if (ok && (data_size % {16'd0, align}) != 0) ok = 1'b0;
          want = '0;
          if (ok) begin
            want.wave_ok          = 1'b1;
            want.format_tag       = code;
            want.channel_count    = chans;
            want.sample_rate      = rate;
            want.bytes_per_second = bps;
            want.block_alignment  = align;
            want.sample_bits      = depth;
            want.payload_offset   = body_offset;
            want.payload_size     = data_size;
          end
          verdict_q.push_back(want);
          clear_parser();
        end
      end

      if (out_valid_i && !out_stall_i) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MAX_REPORTS)
            $display("verdict %0d: none expected, got ok=%0b", verdicts_seen,
                     out_data_i.wave_ok);
        end else begin
          want = verdict_q.pop_front();
          for (int k = 0; k < NUM_FIELDS; k++) begin
            if (field_val(want, k) != field_val(out_data_i, k)) begin
              mismatch_count_o++;
              if (mismatch_count_o <= MAX_REPORTS)
                $display("verdict %0d: %s expected %h, got %h", verdicts_seen,
                         field_name(k), field_val(want, k), field_val(out_data_i, k));
            end
          end
        end
      end
      verdicts_pending_o <= verdict_q.size();
    end
  end

endmodule

### test/wave_header_chunk_parser_tb.sv
`timescale 1ns / 1ps
// Testbench top for wave_header_chunk_parser: builds WAVE files byte by byte,
// streams them in with random gaps and result stalls, and prints the verdict.
// Depends on whcp_pkg, the parser RTL and wave_header_chunk_parser_checker.
module wave_header_chunk_parser_tb;
  import whcp_pkg::*;

  localparam int          IDLE_PCT      = 22;
  localparam int          MIN_BYTES     = 800;
  localparam int          MIN_RND_FILES = 7;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 60;
  localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
  localparam logic [31:0] TAG_JUNK      = 32'h4A55_4E4B;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_req    = '0;
  logic       out_stall = 1'b0;
  logic       calm      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_res;
  int         mismatches;
  int         pending;
  logic [7:0] file_bytes[$];
  int         bytes_sent = 0;
  int         quiet = 0;

  wave_header_chunk_parser #(.POSITION_WIDTH(32)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_res)
  );

  wave_header_chunk_parser_checker #(.POSITION_WIDTH(32)) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_req),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_res),
    .mismatch_count_o  (mismatches),
    .verdicts_pending_o(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // no request and no result moving for too long means a hang
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void push_tag(input logic [31:0] tag);
    for (int k = 3; k >= 0; k--) file_bytes.push_back(tag[8 * k +: 8]);
  endfunction

  function automatic logic [127:0] fmt_lead(input logic [15:0] code, input logic [15:0] chans,
                                             input logic [31:0] rate, input logic [31:0] bps,
                                             input logic [15:0] align, input logic [15:0] depth);
    return {depth, align, bps, rate, chans, code};
  endfunction

  function automatic logic [127:0] noise_lead();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic void push_head(input bit good);
    int idx;
    push_tag(TAG_RIFF);
    for (int k = 0; k < 4; k++) file_bytes.push_back(8'($urandom));
    push_tag(TAG_WAVE);
    if (!good) begin
      idx = $urandom_range(7);
      if (idx >= 4) idx += 4;
      file_bytes[idx] ^= 8'h01 << $urandom_range(7);
    end
  endfunction

  // lead supplies the first 16 body bytes; body_len below size cuts the chunk short
  function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] size,
                                     input int body_len, input bit with_pad,
                                     input logic [127:0] lead);
    push_tag(tag);
    for (int k = 0; k < 4; k++) file_bytes.push_back(size[8 * k +: 8]);
    for (int k = 0; k < body_len; k++) begin
      if (k < 16) file_bytes.push_back(lead[8 * k +: 8]);
      else file_bytes.push_back(8'($urandom));
    end
    if (with_pad && size[0] && body_len == size) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void build_wave(input logic [15:0] code, input logic [15:0] chans,
                                     input logic [31:0] rate, input logic [31:0] bps,
                                     input logic [15:0] align, input logic [15:0] depth,
                                     input logic [31:0] dsize);
    push_head(1'b1);
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1, fmt_lead(code, chans, rate, bps, align, depth));
    push_chunk(TAG_DATA, dsize, dsize, 1'b1, noise_lead());
  endfunction

  task automatic send_file();
    int n;
    n = file_bytes.size();
    for (int i = 0; i < n; i++) begin
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_req <= {file_bytes[i], 1'(i == n - 1)};
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    bytes_sent += n;
    file_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly well-formed files with random content, some noise and broken ones
  task automatic gen_file();
    int          pick;
    int          fsize;
    int          fmt_left;
    int          n;
    int          j;
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] depth;
    logic [31:0] rate;
    logic [31:0] bps;
    logic [31:0] dsize;
    logic [31:0] otag;
    kind_e       order[$];
    kind_e       swap;
    bit          pad;
    pick = $urandom_range(99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
      return;
    end
    push_head($urandom_range(99) >= 3);

    code = ($urandom_range(99) < 90) ? ($urandom_range(1) ? FMT_PCM : FMT_FLOAT)
                                     : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 90) chans = 16'($urandom_range(1, 2));
    else if (pick < 95) chans = $urandom_range(1) ? 16'd3 : 16'd0;
    else chans = 16'($urandom);
    rate = ($urandom_range(99) < 4) ? 32'd0 : $urandom;
    bps = ($urandom_range(99) < 4) ? 32'd0 : $urandom;
    depth = ($urandom_range(99) < 4) ? 16'd0 : 16'($urandom_range(1, 65535));
    pick = $urandom_range(99);
    if (pick < 4) align = 16'd0;
    else if (pick < 8) align = 16'($urandom);
    else align = 16'($urandom_range(1, 8));
    if (align == 0 || align > 8 || $urandom_range(99) < 12) dsize = $urandom_range(0, 12);
    else dsize = align * $urandom_range(1, 3);

    pick = $urandom_range(99);
    fmt_left = (pick < 5) ? 0 : (pick < 90) ? 1 : 2;
    repeat (fmt_left) order.push_back(KIND_FMT);
    if ($urandom_range(99) >= 5) order.push_back(KIND_DATA);
    repeat ($urandom_range(0, 2)) order.push_back(KIND_OTHER);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end

    for (int i = 0; i < order.size(); i++) begin
      pad = (i != order.size() - 1) || ($urandom_range(99) < 70);
      case (order[i])
        KIND_FMT: begin
          fsize = ($urandom_range(99) < 90) ? $urandom_range(16, 19) : $urandom_range(10, 15);
          // an earlier fmt chunk carries junk that the last one overwrites
          if (fmt_left > 1) push_chunk(TAG_FMT, fsize, fsize, pad, noise_lead());
          else push_chunk(TAG_FMT, fsize, fsize, pad,
                          fmt_lead(code, chans, rate, bps, align, depth));
          fmt_left--;
        end
        KIND_DATA: push_chunk(TAG_DATA, dsize, dsize, pad, noise_lead());
        default: begin
          otag = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                  8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
          fsize = $urandom_range(0, 9);
          push_chunk(otag, fsize, fsize, pad, noise_lead());
        end
      endcase
    end

    pick = $urandom_range(99);
    n = file_bytes.size();
    if (pick < 8) begin
      repeat ($urandom_range(1, 7)) file_bytes.push_back(8'($urandom));
    end else if (pick < 16) begin
      repeat ($urandom_range(1, (n - 1 < 20) ? n - 1 : 20)) void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    int rnd_files;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_wave(FMT_PCM, 16'd1, 32'd44100, 32'd88200, 16'd2, 16'd16, 32'd4);
    send_file();
    // odd chunk with pad ahead of a long fmt chunk
    push_head(1'b1);
    push_chunk(TAG_JUNK, 32'd3, 3, 1'b1, noise_lead());
    push_chunk(TAG_FMT, 32'd18, 18, 1'b1,
               fmt_lead(FMT_FLOAT, 16'd2, 32'd48000, 32'd384000, 16'd8, 16'd32));
    push_chunk(TAG_DATA, 32'd16, 16, 1'b1, noise_lead());
    send_file();
    build_wave(FMT_PCM, 16'd2, '1, '1, 16'd3, '1, 32'd3);
    send_file();
    file_bytes.push_back(8'hFF);
    send_file();
    push_head(1'b1);
    void'(file_bytes.pop_back());
    send_file();
    push_head(1'b1);
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 32'd2);
    file_bytes[0] = 8'h72;
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 32'd2);
    file_bytes[9] = 8'h61;
    send_file();
    // data body cut short by the end of file
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd16000, 16'd2, 16'd16, 32'd8);
    repeat (3) void'(file_bytes.pop_back());
    send_file();
    push_head(1'b1);
    push_chunk(TAG_FMT, 32'd14, 14, 1'b1,
               fmt_lead(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8));
    push_chunk(TAG_DATA, 32'd4, 4, 1'b1, noise_lead());
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 32'd0);
    send_file();
    push_head(1'b1);
    push_chunk(TAG_DATA, 32'd4, 4, 1'b1, noise_lead());
    send_file();
    push_head(1'b1);
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8));
    send_file();
    build_wave(16'd2, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 32'd2);
    send_file();
    build_wave(FMT_PCM, 16'd3, 32'd8000, 32'd24000, 16'd3, 16'd8, 32'd3);
    send_file();
    build_wave(FMT_PCM, 16'd0, 32'd8000, 32'd8000, 16'd1, 16'd8, 32'd2);
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd0, 32'd8000, 16'd1, 16'd8, 32'd2);
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd0, 16'd1, 16'd8, 32'd2);
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd0, 16'd8, 32'd4);
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd0, 32'd2);
    send_file();
    build_wave(FMT_PCM, 16'd1, 32'd8000, 32'd32000, 16'd4, 16'd32, 32'd6);
    send_file();
    // trailing header fragment is ignored
    build_wave(FMT_FLOAT, 16'd2, 32'd96000, 32'd768000, 16'd8, 16'd32, 32'd8);
    repeat (5) file_bytes.push_back(8'($urandom));
    send_file();
    // odd data chunk at the end without its pad byte
    build_wave(FMT_FLOAT, 16'd1, 32'd11025, 32'd11025, 16'd1, 16'd8, 32'd3);
    void'(file_bytes.pop_back());
    send_file();
    push_head(1'b1);
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(16'hFFFE, 16'd9, 32'd1, 32'd1, 16'd1, 16'd1));
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(FMT_PCM, 16'd2, 32'd22050, 32'd88200, 16'd4, 16'd16));
    push_chunk(TAG_DATA, 32'd8, 8, 1'b1, noise_lead());
    send_file();
    push_head(1'b1);
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(FMT_PCM, 16'd2, 32'd22050, 32'd88200, 16'd4, 16'd16));
    push_chunk(TAG_DATA, 32'd8, 8, 1'b1, noise_lead());
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(16'hFFFE, 16'd2, 32'd22050, 32'd88200, 16'd4, 16'd16));
    send_file();
    // data ahead of fmt
    push_head(1'b1);
    push_chunk(TAG_DATA, 32'd6, 6, 1'b1, noise_lead());
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(FMT_PCM, 16'd1, 32'd16000, 32'd32000, 16'd2, 16'd16));
    send_file();
    push_head(1'b1);
    push_chunk(TAG_FMT, 32'd16, 16, 1'b1,
               fmt_lead(FMT_PCM, 16'd1, 32'd16000, 32'd32000, 16'd2, 16'd16));
    push_chunk(TAG_DATA, '1, 4, 1'b0, noise_lead());
    send_file();
    wait_drained();

    rnd_files = 0;
    while (bytes_sent < MIN_BYTES || rnd_files < MIN_RND_FILES) begin
      calm <= (rnd_files >= 1 && rnd_files < 5);
      if (rnd_files == 5) wait_drained();
      gen_file();
      send_file();
      rnd_files++;
    end
    calm <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) $display("%0d verdicts never arrived", pending);
    if (mismatches == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
